### design/pvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvt_pkg: shared types and constants for the page validity tracker
// Operation and status codes, controller/datapath command and status words.
// ----------------------------------------------------------------------------
package pvt_pkg;

  localparam int BUFFER_SIZE_LOG2_DEF = 29;
  localparam int MAX_WINDOW_PAGES_DEF = 127;
  localparam int PS_MIN               = 12;   // smallest page size log2
  localparam int PS_MAX               = 16;   // largest page size log2
  localparam int PS_RESET             = 12;
  localparam int PSL_W                = 5;
  localparam int WORD_W               = 32;

  typedef enum logic [1:0] {
    OP_MARK   = 2'd0,
    OP_UPLOAD = 2'd1,
    OP_INVAL  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_IGNORED  = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  // which payload the output register is loaded from
  typedef enum logic [1:0] {
    RS_PLAIN = 2'd0,
    RS_INV   = 2'd1,
    RS_HOLD  = 2'd2
  } resp_sel_t;

  // read address source of the bitmap memories
  typedef enum logic [1:0] {
    RA_BLK  = 2'd0,
    RA_END  = 2'd1,
    RA_PAGE = 2'd2
  } addr_sel_t;

  typedef struct packed {
    logic      latch;
    logic      dec1;
    logic      dec2;
    logic      clr_wr;
    logic      rd_en;
    addr_sel_t rd_sel;
    logic      mod_wr;
    logic      blk_inc;
    logic      w_s1;
    logic      w_hi;
    logic      w_lo_fin;
    logic      w_hi_fin;
    logic      scan_en;
    logic      fin_close;
    logic      push;
    resp_sel_t push_sel;
    status_t   push_status;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic flag;
    logic ign;
    logic up_bad;
    logic up_long;
    logic pf_lo_nz;
    logic pl_lo_nf;
    logic blk_last;
    logic scan_stall;
    logic scan_done;
    logic scan_wrap;
    logic run_open;
    logic out_free;
  } sts_t;

endpackage

### design/pvt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvt_if: valid/ready channels of the page validity tracker
// Request, result and configuration channels.
// ----------------------------------------------------------------------------
interface pvt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] address;
  logic [31:0] byte_length;
  logic [31:0] first_page;
  logic [31:0] last_page;
  logic        flag;

  modport source (output valid, operation, address, byte_length, first_page,
                  last_page, flag, input ready);
  modport sink (input valid, operation, address, byte_length, first_page,
                last_page, flag, output ready);
endinterface

interface pvt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] result_start;
  logic [31:0] result_length;
  logic        last;

  modport source (output valid, status, result_start, result_length, last,
                  input ready);
  modport sink (input valid, status, result_start, result_length, last,
                output ready);
endinterface

interface pvt_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] page_size_log2;

  modport source (output valid, page_size_log2, input ready);
  modport sink (input valid, page_size_log2, output ready);
endinterface

### design/pvt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvt_datapath: bitmap memories, range math and result register
// Executes controller commands; one bitmap block per read/modify/write pair.
// ----------------------------------------------------------------------------
module pvt_datapath #(
  parameter int BUF_LOG2 = pvt_pkg::BUFFER_SIZE_LOG2_DEF,
  parameter int MAX_WIN  = pvt_pkg::MAX_WINDOW_PAGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pvt_pkg::cmd_t       cmd,
  output pvt_pkg::sts_t       sts,
  input  logic [1:0]          in_operation,
  input  logic [31:0]         in_address,
  input  logic [31:0]         in_byte_length,
  input  logic [31:0]         in_first_page,
  input  logic [31:0]         in_last_page,
  input  logic                in_flag,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic [31:0]         out_result_start,
  output logic [31:0]         out_result_length,
  output logic                out_last
);

  localparam int PW     = BUF_LOG2 - 12;     // page number bits
  localparam int BW     = BUF_LOG2 - 18;     // block index bits
  localparam int BLOCKS = 1 << BW;
  localparam logic [32:0] BUF_SIZE = 33'(1) << BUF_LOG2;

  // configuration
  logic [4:0] psl_r;
  logic [4:0] ps;

  // latched request
  pvt_pkg::op_t op_r;
  logic [31:0]  addr_r, len_r, fp_r, lp_r;
  logic         flag_r;

  // decoded range
  logic          ign_r;
  logic [31:0]   lastb_r;
  logic [PW-1:0] lpc_r, pf_r, pl_r, pc_m1;
  logic [BW-1:0] blk_r, end_r, raddr;

  // memories
  logic [63:0] mem_v [BLOCKS];
  logic [63:0] mem_g [BLOCKS];
  logic [63:0] rdv_r, rdg_r, wv, wg, rmask;
  logic        mem_we;

  // widening search
  logic [63:0] w_word;
  logic [7:0]  any_c, any_r;
  logic [2:0]  hix_c [8];
  logic [2:0]  lox_c [8];
  logic [2:0]  hix_r [8];
  logic [2:0]  lox_r [8];
  logic [6:0]  top_c, low_c;
  logic [PW-1:0] pln_c;

  // run scan
  logic [PW-1:0] p_r, run_r, hold_s_r;
  logic [PW:0]   hold_l_r, fin_len;
  logic          open_r, hold_v_r;
  logic          v_bit, close_scan, scan_stall, fin_stall, out_free;
  logic          scan_adv, scan_open, scan_close, fin_go, int_push, push_any;

  // result register
  logic        out_v_r, out_last_r;
  logic [1:0]  out_st_r;
  logic [31:0] out_s_r, out_l_r;
  logic [1:0]  st_nxt;
  logic [31:0] s_nxt, l_nxt;
  logic        last_nxt;
  logic [32:0] inv_s;
  logic [33:0] inv_l;

  // misc combinational
  logic [32:0]   sum_c;
  logic          ign_c;
  logic [31:0]   lastb_c;
  logic [PW-1:0] lpc_c, pf_c, pl_c;

  always_comb begin
    if (psl_r < 5'(pvt_pkg::PS_MIN)) begin
      ps = 5'(pvt_pkg::PS_MIN);
    end else if (psl_r > 5'(pvt_pkg::PS_MAX)) begin
      ps = 5'(pvt_pkg::PS_MAX);
    end else begin
      ps = psl_r;
    end
  end

  assign pc_m1 = {PW{1'b1}} >> (ps - 5'(pvt_pkg::PS_MIN));

  // byte range: one add and compare, then the page shifts in the next cycle
  assign sum_c   = {1'b0, addr_r} + {1'b0, len_r};
  assign ign_c   = (len_r == '0) || ({1'b0, addr_r} >= BUF_SIZE);
  assign lastb_c = (sum_c > BUF_SIZE) ? 32'(BUF_SIZE - 33'd1) : 32'(sum_c - 33'd1);
  assign lpc_c   = (lp_r > 32'(pc_m1)) ? pc_m1 : PW'(lp_r);
  assign pf_c    = PW'(addr_r >> ps);
  assign pl_c    = PW'(lastb_r >> ps);

  // block mask of the current range
  always_comb begin
    rmask = {64{1'b1}};
    if (blk_r == pf_r[PW-1:6]) rmask = rmask & ({64{1'b1}} << pf_r[5:0]);
    if (blk_r == pl_r[PW-1:6]) rmask = rmask & ({64{1'b1}} >> (6'd63 - pl_r[5:0]));
  end

  always_comb begin
    mem_we = cmd.clr_wr || cmd.mod_wr;
    wv = '0;
    wg = '0;
    if (cmd.mod_wr) begin
      case (op_r)
        pvt_pkg::OP_MARK: begin
          wv = rdv_r | rmask;
          wg = flag_r ? (rdg_r | rmask) : (rdg_r & ~rmask);
        end
        pvt_pkg::OP_INVAL: begin
          wv = rdv_r & ~rmask;
          wg = rdg_r & ~rmask;
        end
        default: begin
          wv = rdg_r;
          wg = rdg_r;
        end
      endcase
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      pvt_pkg::RA_BLK: raddr = blk_r;
      pvt_pkg::RA_END: raddr = end_r;
      default:         raddr = p_r[PW-1:6];
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_v[blk_r] <= wv;
    if (cmd.rd_en) rdv_r <= mem_v[raddr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_g[blk_r] <= wg;
    if (cmd.rd_en) rdg_r <= mem_g[raddr];
  end

  // widening: byte lanes first, then across the eight lanes
  assign w_word = cmd.w_hi ? (rdg_r & (({64{1'b1}} << pl_r[5:0]) << 1))
                           : (rdg_r & ~({64{1'b1}} << pf_r[5:0]));

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      any_c[j] = |w_word[8*j +: 8];
      hix_c[j] = '0;
      lox_c[j] = '0;
      for (int b = 0; b < 8; b++) begin
        if (w_word[8*j + b]) hix_c[j] = 3'(b);
      end
      for (int b = 7; b >= 0; b--) begin
        if (w_word[8*j + b]) lox_c[j] = 3'(b);
      end
    end
  end

  always_comb begin
    top_c = '0;
    low_c = 7'd64;
    for (int j = 0; j < 8; j++) begin
      if (any_r[j]) top_c = 7'({3'(j), hix_r[j]}) + 7'd1;
    end
    for (int j = 7; j >= 0; j--) begin
      if (any_r[j]) low_c = 7'({3'(j), lox_r[j]});
    end
    pln_c = {pl_r[PW-1:6], 6'(low_c - 7'd1)};
    if (pln_c > pc_m1) pln_c = pc_m1;
  end

  // run scan over the window
  assign out_free   = !out_v_r || out_ready;
  assign v_bit      = rdv_r[p_r[5:0]];
  assign close_scan = open_r && v_bit;
  assign scan_stall = close_scan && hold_v_r && !out_free;
  assign fin_stall  = hold_v_r && !out_free;
  assign scan_adv   = cmd.scan_en && !scan_stall;
  assign scan_open  = scan_adv && !open_r && !v_bit;
  assign scan_close = scan_adv && close_scan;
  assign fin_go     = cmd.fin_close && open_r && !fin_stall;
  assign fin_len    = {1'b0, lpc_r} + (PW+1)'(1) - {1'b0, run_r};
  assign int_push   = (scan_close || fin_go) && hold_v_r;
  assign push_any   = cmd.push || int_push;

  // result payload
  assign inv_s = 33'(pf_r) << ps;
  assign inv_l = (34'(pl_r - pf_r) + 34'd1) << ps;

  always_comb begin
    st_nxt   = pvt_pkg::ST_OK;
    s_nxt    = '0;
    l_nxt    = '0;
    last_nxt = 1'b1;
    if (int_push) begin
      s_nxt    = 32'(hold_s_r);
      l_nxt    = 32'(hold_l_r);
      last_nxt = 1'b0;
    end else begin
      case (cmd.push_sel)
        pvt_pkg::RS_INV: begin
          s_nxt = inv_s[31:0];
          l_nxt = (inv_l[33:32] != 2'b00) ? {32{1'b1}} : inv_l[31:0];
        end
        pvt_pkg::RS_HOLD: begin
          s_nxt = hold_v_r ? 32'(hold_s_r) : '0;
          l_nxt = hold_v_r ? 32'(hold_l_r) : '0;
        end
        default: begin
          st_nxt = cmd.push_status;
          // an ignored invalidate answers with an all-ones length
          if (op_r == pvt_pkg::OP_INVAL && cmd.push_status == pvt_pkg::ST_IGNORED) begin
            l_nxt = {32{1'b1}};
          end
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psl_r    <= 5'(pvt_pkg::PS_RESET);
      blk_r    <= '0;
      end_r    <= '1;
      open_r   <= 1'b0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_we) psl_r <= cfg_data;
      if (cmd.dec2) begin
        blk_r    <= (op_r == pvt_pkg::OP_CLEAR) ? '0 : pf_c[PW-1:6];
        end_r    <= (op_r == pvt_pkg::OP_CLEAR) ? '1 : pl_c[PW-1:6];
        open_r   <= 1'b0;
        hold_v_r <= 1'b0;
      end else if (cmd.blk_inc) begin
        blk_r <= blk_r + BW'(1);
      end
      if (scan_open) open_r <= 1'b1;
      if (scan_close || fin_go) begin
        open_r   <= 1'b0;
        hold_v_r <= 1'b1;
      end
      if (push_any) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= pvt_pkg::op_t'(in_operation);
      addr_r <= in_address;
      len_r  <= in_byte_length;
      fp_r   <= in_first_page;
      lp_r   <= in_last_page;
      flag_r <= in_flag;
    end
    if (cmd.dec1) begin
      ign_r   <= ign_c;
      lastb_r <= lastb_c;
      lpc_r   <= lpc_c;
    end
    if (cmd.dec2) begin
      pf_r <= pf_c;
      pl_r <= pl_c;
      p_r  <= PW'(fp_r);
    end
    if (cmd.w_lo_fin) pf_r <= {pf_r[PW-1:6], top_c[5:0]};
    if (cmd.w_hi_fin) pl_r <= pln_c;
    if (cmd.w_s1) begin
      any_r <= any_c;
      hix_r <= hix_c;
      lox_r <= lox_c;
    end
    if (scan_open) run_r <= p_r;
    if (scan_close) begin
      hold_s_r <= run_r;
      hold_l_r <= {1'b0, p_r - run_r};
    end
    if (fin_go) begin
      hold_s_r <= run_r;
      hold_l_r <= fin_len;
    end
    if (scan_adv && (p_r != lpc_r)) p_r <= p_r + PW'(1);
    if (push_any) begin
      out_st_r   <= st_nxt;
      out_s_r    <= s_nxt;
      out_l_r    <= l_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign out_valid         = out_v_r;
  assign out_status        = out_st_r;
  assign out_result_start  = out_s_r;
  assign out_result_length = out_l_r;
  assign out_last          = out_last_r;

  always_comb begin
    sts.op         = op_r;
    sts.flag       = flag_r;
    sts.ign        = ign_r;
    sts.up_bad     = fp_r > 32'(lpc_r);
    sts.up_long    = (32'(lpc_r) - fp_r) >= 32'(MAX_WIN);
    sts.pf_lo_nz   = pf_r[5:0] != '0;
    sts.pl_lo_nf   = pl_r[5:0] != '1;
    sts.blk_last   = blk_r == end_r;
    sts.scan_stall = scan_stall;
    sts.scan_done  = p_r == lpc_r;
    sts.scan_wrap  = p_r[5:0] == '1;
    sts.run_open   = open_r;
    sts.out_free   = out_free;
  end

endmodule

### design/pvt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvt_ctrl: operation sequencer of the page validity tracker
// One-hot state machine issuing datapath commands.
// ----------------------------------------------------------------------------
module pvt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pvt_pkg::sts_t sts,
  output pvt_pkg::cmd_t cmd
);

  typedef enum logic [15:0] {
    S_CLR   = 16'h0001,
    S_IDLE  = 16'h0002,
    S_DEC1  = 16'h0004,
    S_DEC2  = 16'h0008,
    S_LO_RD = 16'h0010,
    S_LO_S1 = 16'h0020,
    S_LO_S2 = 16'h0040,
    S_HI_RD = 16'h0080,
    S_HI_S1 = 16'h0100,
    S_HI_S2 = 16'h0200,
    S_RD    = 16'h0400,
    S_MOD   = 16'h0800,
    S_URD   = 16'h1000,
    S_USCAN = 16'h2000,
    S_UFIN  = 16'h4000,
    S_RESP  = 16'h8000
  } fsm_t;

  fsm_t                state_r, state_nxt;
  pvt_pkg::resp_sel_t  rsel_r, rsel_nxt;
  pvt_pkg::status_t    rst_r, rst_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    rsel_nxt  = rsel_r;
    rst_nxt   = rst_r;
    case (state_r)
      S_CLR: begin
        cmd.clr_wr  = 1'b1;
        cmd.blk_inc = 1'b1;
        if (sts.blk_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DEC1;
        end
      end
      S_DEC1: begin
        cmd.dec1  = 1'b1;
        state_nxt = S_DEC2;
      end
      S_DEC2: begin
        cmd.dec2 = 1'b1;
        rsel_nxt = pvt_pkg::RS_PLAIN;
        case (sts.op)
          pvt_pkg::OP_CLEAR: state_nxt = S_RD;
          pvt_pkg::OP_UPLOAD: begin
            if (sts.up_bad) begin
              rst_nxt   = pvt_pkg::ST_IGNORED;
              state_nxt = S_RESP;
            end else if (sts.up_long) begin
              rst_nxt   = pvt_pkg::ST_TOO_LONG;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_URD;
            end
          end
          default: begin
            if (sts.ign) begin
              rst_nxt   = pvt_pkg::ST_IGNORED;
              state_nxt = S_RESP;
            end else if (sts.op == pvt_pkg::OP_INVAL && !sts.flag) begin
              state_nxt = S_LO_RD;
            end else begin
              state_nxt = S_RD;
            end
          end
        endcase
      end
      S_LO_RD: begin
        if (sts.pf_lo_nz) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = pvt_pkg::RA_BLK;
          state_nxt  = S_LO_S1;
        end else begin
          state_nxt = S_HI_RD;
        end
      end
      S_LO_S1: begin
        cmd.w_s1  = 1'b1;
        state_nxt = S_LO_S2;
      end
      S_LO_S2: begin
        cmd.w_lo_fin = 1'b1;
        state_nxt    = S_HI_RD;
      end
      S_HI_RD: begin
        if (sts.pl_lo_nf) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = pvt_pkg::RA_END;
          state_nxt  = S_HI_S1;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_HI_S1: begin
        cmd.w_s1  = 1'b1;
        cmd.w_hi  = 1'b1;
        state_nxt = S_HI_S2;
      end
      S_HI_S2: begin
        cmd.w_hi_fin = 1'b1;
        state_nxt    = S_RD;
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = pvt_pkg::RA_BLK;
        state_nxt  = S_MOD;
      end
      S_MOD: begin
        cmd.mod_wr = 1'b1;
        if (sts.blk_last) begin
          rsel_nxt  = (sts.op == pvt_pkg::OP_INVAL) ? pvt_pkg::RS_INV : pvt_pkg::RS_PLAIN;
          rst_nxt   = pvt_pkg::ST_OK;
          state_nxt = S_RESP;
        end else begin
          cmd.blk_inc = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_URD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = pvt_pkg::RA_PAGE;
        state_nxt  = S_USCAN;
      end
      S_USCAN: begin
        cmd.scan_en = 1'b1;
        if (!sts.scan_stall) begin
          if (sts.scan_done) begin
            state_nxt = S_UFIN;
          end else if (sts.scan_wrap) begin
            state_nxt = S_URD;
          end
        end
      end
      S_UFIN: begin
        if (sts.run_open) begin
          cmd.fin_close = 1'b1;
        end else if (sts.out_free) begin
          cmd.push     = 1'b1;
          cmd.push_sel = pvt_pkg::RS_HOLD;
          state_nxt    = S_IDLE;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.push        = 1'b1;
          cmd.push_sel    = rsel_r;
          cmd.push_status = rst_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      rsel_r  <= pvt_pkg::RS_PLAIN;
      rst_r   <= pvt_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      rsel_r  <= rsel_nxt;
      rst_r   <= rst_nxt;
    end
  end

endmodule

### design/page_validity_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_validity_tracker: valid / GPU-written page bitmaps of a buffer
// Sequencer plus datapath with two block memories of 64-bit words.
// ----------------------------------------------------------------------------
// Handles one request word at a time; the next is taken once the previous
// one is finished, even while its last result word still waits in the output
// register. Both bitmaps live in single-port-write memories of 2^(B-18)
// 64-bit blocks (B = BUFFER_SIZE_LOG2; 2048 blocks by default) and every
// block of a request is read and then written back. After reset the block
// runs a clearing pass of one block per cycle with in_ch.ready low.
// mark_valid and invalidate latch and decode the request, read and write
// back each touched block and push one result; a non-exact invalidate first
// widens its range over the GPU-written pages of its edge blocks.
// request_upload reads and scans its window of up to MAX_WINDOW_PAGES pages
// page by page and waits while the result side stalls; clear_cache reads
// and rewrites every block. Ignored requests are answered straight after decoding.
// page_size_log2 is clamped to 12..16 and may be written only while idle.
// ----------------------------------------------------------------------------
module page_validity_tracker #(
  parameter int BUFFER_SIZE_LOG2 = pvt_pkg::BUFFER_SIZE_LOG2_DEF,
  parameter int MAX_WINDOW_PAGES = pvt_pkg::MAX_WINDOW_PAGES_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  pvt_in_if.sink   in_ch,
  pvt_out_if.source out_ch,
  pvt_cfg_if.sink  cfg_ch
);

  pvt_pkg::cmd_t cmd;
  pvt_pkg::sts_t sts;

  // the register write is always taken
  assign cfg_ch.ready = 1'b1;

  pvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pvt_datapath #(
    .BUF_LOG2 (BUFFER_SIZE_LOG2),
    .MAX_WIN  (MAX_WINDOW_PAGES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_operation      (in_ch.operation),
    .in_address        (in_ch.address),
    .in_byte_length    (in_ch.byte_length),
    .in_first_page     (in_ch.first_page),
    .in_last_page      (in_ch.last_page),
    .in_flag           (in_ch.flag),
    .cfg_we            (cfg_ch.valid),
    .cfg_data          (cfg_ch.page_size_log2),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_status        (out_ch.status),
    .out_result_start  (out_ch.result_start),
    .out_result_length (out_ch.result_length),
    .out_last          (out_ch.last)
  );

endmodule

### design/pvt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvt_checker: port-level checks of the page validity tracker
// Bound to the top level.
// ----------------------------------------------------------------------------
module pvt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_result_length,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while one is in work");

  a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == pvt_pkg::ST_OK)
    else $error("non-final word with error status");

  a_too_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pvt_pkg::ST_TOO_LONG |-> out_last && out_result_length == '0)
    else $error("too-long window answer malformed");

endmodule

bind page_validity_tracker pvt_checker u_pvt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_result_length (out_ch.result_length),
  .out_last          (out_ch.last)
);

### tb/tb_page_validity_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_validity_tracker: self-checking bench for the page validity tracker
// A queue-fed driver offers request words and a monitor checks every result
// word against a predictor that keeps its own copy of both page bitmaps.
// Runs several page sizes, random idling on both sides and one long stall.
// ----------------------------------------------------------------------------
module tb_page_validity_tracker;
  import pvt_pkg::*;

  localparam int BUF_LOG2  = BUFFER_SIZE_LOG2_DEF;
  localparam int MAX_WIN   = MAX_WINDOW_PAGES_DEF;
  localparam int NBLK      = 1 << (BUF_LOG2 - 18);
  localparam int HOLD_CYC  = 400;   // length of the forced result-side stall
  localparam int IDLE_PCT  = 16;

  typedef struct packed {
    op_t         op;
    logic [31:0] addr;
    logic [31:0] len;
    logic [31:0] fp;
    logic [31:0] lp;
    logic        flag;
  } req_t;

  typedef struct packed {
    status_t     st;
    logic [31:0] start;
    logic [31:0] length;
    logic        last;
  } resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pvt_in_if  in_ch ();
  pvt_out_if out_ch ();
  pvt_cfg_if cfg_ch ();

  page_validity_tracker i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [63:0] valid_bm [NBLK];
  logic [63:0] gpu_bm   [NBLK];
  logic [4:0]  page_log2 = 5'(PS_RESET);

  req_t  pending_words [$];
  resp_t expected_resp [$];

  int errors     = 0;
  int words_sent = 0;
  int resp_seen  = 0;
  int op_count [4];
  bit calm        = 1'b0;   // no random idling on either side
  bit pressure_on = 1'b0;
  int hold_cnt    = 0;

  initial begin
    foreach (valid_bm[i]) begin
      valid_bm[i] = '0;
      gpu_bm[i]   = '0;
    end
    foreach (op_count[i]) op_count[i] = 0;
  end

  function automatic int unsigned eff_ps();
    if (page_log2 < PS_MIN) return PS_MIN;
    if (page_log2 > PS_MAX) return PS_MAX;
    return page_log2;
  endfunction

  function automatic logic [63:0] blk_mask(int unsigned i, int unsigned pf, int unsigned pl);
    logic [63:0] m;
    m = '1;
    if (i == (pf >> 6)) m &= ('1 << (pf & 63));
    if (i == (pl >> 6) && (pl & 63) != 63) m &= (64'd1 << ((pl & 63) + 1)) - 64'd1;
    return m;
  endfunction

  function automatic void push_resp(status_t st, logic [31:0] s, logic [31:0] l, logic lst);
    resp_t r;
    r.st = st; r.start = s; r.length = l; r.last = lst;
    expected_resp = {expected_resp, r};
  endfunction

  // Applies one accepted request to the bitmap copy and queues its results.
  function automatic void track_request(req_t r);
    int unsigned ps, pcount, pf, pl, bf, bl, lp, top, low, run_start;
    logic [63:0] bufsz, a, len, g, m, s, l;
    bit open;
    resp_t runs [$];
    resp_t x;
    ps = eff_ps();
    bufsz = 64'd1 << BUF_LOG2;
    pcount = 32'(bufsz >> ps);
    op_count[r.op]++;
    case (r.op)
      OP_CLEAR: begin
        foreach (valid_bm[i]) valid_bm[i] = gpu_bm[i];
        push_resp(ST_OK, '0, '0, 1'b1);
      end
      OP_UPLOAD: begin
        lp = (r.lp > pcount - 1) ? pcount - 1 : r.lp;
        if (r.fp > lp) push_resp(ST_IGNORED, '0, '0, 1'b1);
        else if (lp - r.fp >= MAX_WIN) push_resp(ST_TOO_LONG, '0, '0, 1'b1);
        else begin
          open = 1'b0;
          run_start = 0;
          for (longint unsigned p = r.fp; p <= lp; p++) begin
            if (!open && !valid_bm[p >> 6][p & 63]) begin
              open = 1'b1;
              run_start = 32'(p);
            end else if (open && valid_bm[p >> 6][p & 63]) begin
              x.st = ST_OK; x.start = run_start; x.length = 32'(p) - run_start; x.last = 0;
              runs = {runs, x};
              open = 1'b0;
            end
          end
          if (open) begin
            x.st = ST_OK; x.start = run_start; x.length = lp + 1 - run_start; x.last = 0;
            runs = {runs, x};
          end
          if (runs.size() == 0) push_resp(ST_OK, '0, '0, 1'b1);
          else begin
            runs[runs.size() - 1].last = 1'b1;
            foreach (runs[k]) expected_resp = {expected_resp, runs[k]};
          end
        end
      end
      default: begin
        a = {32'd0, r.addr};
        len = {32'd0, r.len};
        if (len == 0 || a >= bufsz) begin
          push_resp(ST_IGNORED, '0, (r.op == OP_INVAL) ? 32'hFFFF_FFFF : 32'd0, 1'b1);
        end else begin
          if (len > bufsz - a) len = bufsz - a;
          pf = 32'(a >> ps);
          pl = 32'((a + len - 1) >> ps);
          bf = pf >> 6;
          bl = pl >> 6;
          if (r.op == OP_MARK) begin
            for (int unsigned i = bf; i <= bl; i++) begin
              m = blk_mask(i, pf, pl);
              valid_bm[i] |= m;
              if (r.flag) gpu_bm[i] |= m;
              else gpu_bm[i] &= ~m;
            end
            push_resp(ST_OK, '0, '0, 1'b1);
          end else begin
            // non-exact: widen down/up to the nearest GPU-written page in the edge blocks
            if (!r.flag) begin
              if ((pf & 63) != 0) begin
                g = gpu_bm[bf] & ((64'd1 << (pf & 63)) - 64'd1);
                top = 0;
                for (int b = 0; b < 64; b++) if (g[b]) top = b + 1;
                pf = (pf & ~32'd63) + top;
              end
              if ((pl & 63) != 63) begin
                g = gpu_bm[bl] & ~((64'd1 << ((pl & 63) + 1)) - 64'd1);
                low = 64;
                for (int b = 63; b >= 0; b--) if (g[b]) low = b;
                pl = (pl & ~32'd63) + low - 1;
                if (pl > pcount - 1) pl = pcount - 1;
              end
            end
            for (int unsigned i = bf; i <= bl; i++) begin
              m = blk_mask(i, pf, pl);
              valid_bm[i] &= ~m;
              gpu_bm[i]   &= ~m;
            end
            s = {32'd0, pf} << ps;
            l = ({32'd0, pl - pf} + 64'd1) << ps;
            if (l > 64'hFFFF_FFFF) l = 64'hFFFF_FFFF;
            push_resp(ST_OK, s[31:0], l[31:0], 1'b1);
          end
        end
      end
    endcase
  endfunction

  // driver: offers queued words, predicts each one as it is taken
  always @(posedge clk) begin
    bit offering;
    req_t w;
    if (rst_n) begin
      offering = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        track_request({op_t'(in_ch.operation), in_ch.address, in_ch.byte_length,
                       in_ch.first_page, in_ch.last_page, in_ch.flag});
        words_sent++;
        offering = 1'b0;
      end
      if (!offering && pending_words.size() > 0 &&
          (calm || $urandom_range(99) >= IDLE_PCT)) begin
        w = pending_words.pop_front();
        in_ch.operation   <= w.op;
        in_ch.address     <= w.addr;
        in_ch.byte_length <= w.len;
        in_ch.first_page  <= w.fp;
        in_ch.last_page   <= w.lp;
        in_ch.flag        <= w.flag;
        offering = 1'b1;
      end
      in_ch.valid <= offering;
    end
  end

  // long result-side hold-off, counted here
  always @(posedge clk) begin
    if (!pressure_on) hold_cnt <= 0;
    else if (hold_cnt < HOLD_CYC) hold_cnt <= hold_cnt + 1;
  end

  // monitor: compares each result word with the oldest expectation
  always @(posedge clk) begin
    resp_t e;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        resp_seen++;
        if (expected_resp.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word st=%0d start=%h len=%h last=%b", $time,
                   out_ch.status, out_ch.result_start, out_ch.result_length, out_ch.last);
        end else begin
          e = expected_resp.pop_front();
          if (out_ch.status !== e.st) begin
            errors++;
            $display("%0t: status exp %0d got %0d", $time, e.st, out_ch.status);
          end
          if (out_ch.result_start !== e.start) begin
            errors++;
            $display("%0t: result_start exp %h got %h", $time, e.start, out_ch.result_start);
          end
          if (out_ch.result_length !== e.length) begin
            errors++;
            $display("%0t: result_length exp %h got %h", $time, e.length,
                     out_ch.result_length);
          end
          if (out_ch.last !== e.last) begin
            errors++;
            $display("%0t: last exp %b got %b", $time, e.last, out_ch.last);
          end
        end
      end
      out_ch.ready <= !(pressure_on && hold_cnt < HOLD_CYC) &&
                      (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic void add_word(op_t op, logic [31:0] a, logic [31:0] n,
                                   logic [31:0] f, logic [31:0] l, logic fl);
    req_t w;
    w.op = op; w.addr = a; w.len = n; w.fp = f; w.lp = l; w.flag = fl;
    pending_words = {pending_words, w};
  endfunction

  // Random word: mostly ranges clustered near the buffer start or end so that
  // marks, invalidates and uploads hit the same blocks; a few raw 32-bit values.
  function automatic void add_random_word();
    int unsigned ps, pcount, pg, sel;
    logic [63:0] a;
    logic [31:0] n, f;
    op_t op;
    ps = eff_ps();
    pcount = (1 << BUF_LOG2) >> ps;
    sel = $urandom_range(99);
    if (sel < 2) op = OP_CLEAR;
    else if (sel < 40) op = OP_MARK;
    else if (sel < 70) op = OP_UPLOAD;
    else op = OP_INVAL;
    pg = ($urandom_range(3) == 0) ? pcount - 1 - $urandom_range(200) : $urandom_range(300);
    a = ({32'd0, pg} << ps) + ($urandom_range(3) == 0 ? $urandom_range((1 << ps) - 1) : 0);
    case ($urandom_range(7))
      0: n = $urandom();
      1: n = $urandom_range(1 << ps);
      default: n = ($urandom_range(1, 90) << ps) - $urandom_range(1);
    endcase
    if ($urandom_range(11) == 0) a = {32'd0, $urandom()};
    f = pg - $urandom_range(20);
    if ($urandom_range(11) == 0) f = $urandom();
    add_word(op, a[31:0], n, f,
             ($urandom_range(11) == 0) ? $urandom() : f + $urandom_range(140),
             $urandom_range(1));
  endfunction

  task automatic drain();
    while (pending_words.size() > 0 || in_ch.valid || expected_resp.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_page_size(logic [4:0] v);
    @(posedge clk);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.page_size_log2 <= v;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    page_log2 = v;
  endtask

  task automatic random_phase(int n);
    repeat (n) add_random_word();
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_MARK;
    in_ch.address = '0;
    in_ch.byte_length = '0;
    in_ch.first_page = '0;
    in_ch.last_page = '0;
    in_ch.flag = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.page_size_log2 = 5'(PS_RESET);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at the reset page size
    add_word(OP_UPLOAD, 0, 0, 0, 0, 0);                   // fresh: one run
    add_word(OP_MARK, 0, 0, 0, 0, 1);                     // zero length, ignored
    add_word(OP_INVAL, 0, 0, 0, 0, 0);                    // ignored invalidate
    add_word(OP_MARK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1); // past buffer end
    add_word(OP_INVAL, 32'h2000_0000, 5, 0, 0, 1);        // exactly at buffer end
    add_word(OP_MARK, 32'h1FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1); // cut at buffer end
    add_word(OP_MARK, 32'h0000_3000, 32'h0000_5001, 0, 0, 1);
    add_word(OP_MARK, 32'h0004_0000, 32'h0000_1000, 0, 0, 0);
    add_word(OP_MARK, 32'h0003_F000, 32'h0000_1000, 0, 0, 1);
    add_word(OP_UPLOAD, 0, 0, 0, 126, 0);                 // max window, several runs
    add_word(OP_UPLOAD, 0, 0, 0, 127, 0);                 // one page too long
    add_word(OP_UPLOAD, 0, 0, 9, 8, 0);                   // first above last
    add_word(OP_UPLOAD, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0); // clamps, then empty
    add_word(OP_UPLOAD, 0, 0, 131000, 32'hFFFF_FFFF, 0);  // clamped to last page
    add_word(OP_UPLOAD, 0, 0, 3, 8, 0);                   // all valid: no run
    add_word(OP_INVAL, 32'h0000_9000, 32'h0000_1000, 0, 0, 0); // widened
    add_word(OP_INVAL, 32'h0004_0800, 32'h0000_0010, 0, 0, 1); // exact
    add_word(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    add_word(OP_UPLOAD, 0, 0, 0, 70, 1);
    add_word(OP_MARK, 0, 32'h2000_0000, 0, 0, 1);         // whole buffer
    add_word(OP_INVAL, 32'h1000_0000, 32'h0000_0001, 0, 0, 0);
    add_word(OP_INVAL, 0, 32'hFFFF_FFFF, 0, 0, 0);        // whole buffer cleared
    add_word(OP_UPLOAD, 0, 0, 100, 200, 0);
    drain();
    random_phase(40);

    write_page_size(5'd16);
    calm = 1'b1;
    random_phase(40);
    calm = 1'b0;

    // stall the result side while many-run uploads keep coming
    write_page_size(5'd14);
    for (int i = 0; i < 30; i++) add_word(OP_MARK, (2 * i) << 14, 32'h4000, 0, 0, i[0]);
    for (int i = 0; i < 6; i++) add_word(OP_UPLOAD, 0, 0, i, i + 100, 0);
    pressure_on = 1'b1;
    wait (hold_cnt == HOLD_CYC);
    pressure_on = 1'b0;
    drain();
    random_phase(40);

    write_page_size(5'd3);     // acts as the smallest size
    random_phase(40);
    write_page_size(5'd31);    // acts as the largest size
    random_phase(40);
    write_page_size(5'd12);
    random_phase(40);

    repeat (50) @(posedge clk);
    $display("covered %0d request words (mark %0d, upload %0d, invalidate %0d, clear %0d)",
             words_sent, op_count[OP_MARK], op_count[OP_UPLOAD], op_count[OP_INVAL],
             op_count[OP_CLEAR]);
    $display("checked %0d result words over six page size settings, %0d mismatches",
             resp_seen, errors);
    if (errors == 0 && expected_resp.size() == 0)
      $display("[page_validity_tracker] OK");
    else
      $display("[page_validity_tracker] ERROR");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d result words outstanding", expected_resp.size());
    $display("[page_validity_tracker] ERROR");
    $finish;
  end

endmodule
